/* src/rda_pkg.sv */
// rda_pkg: shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none

package rda_pkg;

  // ring geometry
  localparam int RING_DEPTH  = 8;
  localparam int MAX_RESULTS = 7;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int STEP_W      = $clog2(RING_DEPTH);
  localparam int FREE_W      = $clog2(RING_DEPTH + 1);

  // item field widths
  localparam int FUNC_W   = 2;
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 4;
  localparam int NEXT_W   = 3;
  localparam int STATUS_W = 3;
  localparam int GSLOT_W  = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CHAIN = 2'd2;
  localparam logic [FUNC_W-1:0] FN_LINK  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE     = 3'd4;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_ALLOC  = 5'b00100,
    S_CHAIN  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic alloc_step;
    logic chain_step;
    logic emit;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic go_alloc;
    logic go_chain;
    logic alloc_done;
    logic chain_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/ring_descriptor_allocator.sv */
// ring_descriptor_allocator: bitmap slot allocator for a descriptor ring
// Free-one, write-link and rejected allocates: the item is decoded, then a single result is emitted.
// Allocate of N: decoded, then one bitmap slot scanned per cycle, holding at a free slot while
// the output is stalled; each free slot found gives one result, the last one flagged.
// Free-chain: one link followed per cycle, up to RING_DEPTH steps, then a single result is emitted.
// Synchronous reset clears the bitmap, link flags and output valid; every slot starts free.
`timescale 1ns / 1ps
`default_nettype none

module ring_descriptor_allocator
  import rda_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [CNT_W-1:0]    count,
  input  wire logic [IDX_W-1:0]    slot_index,
  input  wire logic                has_next,
  input  wire logic [NEXT_W-1:0]   next_slot,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [GSLOT_W-1:0]       granted_slot,
  output logic                     last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  rda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  rda_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .count        (count),
    .slot_index   (slot_index),
    .has_next     (has_next),
    .next_slot    (next_slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .last         (last)
  );

endmodule

`default_nettype wire

/* src/rda_ctrl.sv */
// rda_ctrl: sequencing state machine of the descriptor allocator
`timescale 1ns / 1ps
`default_nettype none

module rda_ctrl
  import rda_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.go_alloc) begin
          state_next = S_ALLOC;
        end else if (stat.go_chain) begin
          state_next = S_CHAIN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (stat.alloc_done) begin
          state_next = S_IDLE;
        end
      end
      S_CHAIN: begin
        cmd.chain_step = 1'b1;
        if (stat.chain_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rda_dp.sv */
// rda_dp: slot bitmap, link store, scan and walk registers, output register
`timescale 1ns / 1ps
`default_nettype none

module rda_dp
  import rda_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_stat_t                 stat,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [CNT_W-1:0]    count,
  input  wire logic [IDX_W-1:0]    slot_index,
  input  wire logic                has_next,
  input  wire logic [NEXT_W-1:0]   next_slot,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [GSLOT_W-1:0]       granted_slot,
  output logic                     last
);

  // persistent state
  logic [RING_DEPTH-1:0] used_map, used_map_next;
  logic [RING_DEPTH-1:0] link_flag, link_flag_next;
  logic [SLOT_W-1:0]     link_target [RING_DEPTH];
  logic                  link_we;

  // latched item
  logic [FUNC_W-1:0] item_func;
  logic [CNT_W-1:0]  item_count;
  logic [IDX_W-1:0]  item_idx;
  logic              item_has_next;
  logic [NEXT_W-1:0] item_next;

  // scan and walk registers
  logic [SLOT_W-1:0]   ptr, ptr_next;
  logic [CNT_W-1:0]    remaining, remaining_next;
  logic [IDX_W-1:0]    cur, cur_next;
  logic [STEP_W-1:0]   step, step_next;
  logic                any_freed, any_freed_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [GSLOT_W-1:0]  res_slot, res_slot_next;

  // output load
  logic                out_load;
  logic                out_load_last;
  logic [STATUS_W-1:0] out_load_status;
  logic [GSLOT_W-1:0]  out_load_slot;

  logic              out_free;
  logic              item_in_range;
  logic              cur_in_range;
  logic              too_many;
  logic              short_slots;
  logic [FREE_W-1:0] free_cnt;
  logic              alloc_grant;
  logic              chain_end;
  logic              cur_used;

  assign out_free      = !out_valid || !out_stall;
  assign item_in_range = 32'(item_idx) < RING_DEPTH;
  assign cur_in_range  = 32'(cur) < RING_DEPTH;
  assign too_many      = (32'(item_count) >= RING_DEPTH) || (32'(item_count) > MAX_RESULTS);
  assign cur_used      = cur_in_range && used_map[cur[SLOT_W-1:0]];

  // free slot count for the allocate check
  always_comb begin
    free_cnt = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      free_cnt = free_cnt + FREE_W'(!used_map[i]);
    end
  end

  assign short_slots = 32'(free_cnt) < 32'(item_count);
  assign alloc_grant = cmd.alloc_step && !used_map[ptr] && out_free;

  // chain walk stops on a bad index, a slot without link, or the step bound
  assign chain_end = !cur_in_range || !link_flag[cur[SLOT_W-1:0]] ||
                     (step == STEP_W'(RING_DEPTH - 1));

  // status to the controller
  always_comb begin
    stat.go_alloc   = (item_func == FN_ALLOC) && !too_many && (item_count != '0) &&
                      !short_slots;
    stat.go_chain   = (item_func == FN_CHAIN);
    stat.alloc_done = alloc_grant && (remaining == CNT_W'(1));
    stat.chain_done = chain_end;
    stat.out_free   = out_free;
  end

  // operation logic
  always_comb begin
    used_map_next   = used_map;
    link_flag_next  = link_flag;
    link_we         = 1'b0;
    ptr_next        = ptr;
    remaining_next  = remaining;
    cur_next        = cur;
    step_next       = step;
    any_freed_next  = any_freed;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    out_load        = 1'b0;
    out_load_last   = 1'b1;
    out_load_status = res_status;
    out_load_slot   = res_slot;

    // decode of a freshly latched item
    if (cmd.decode) begin
      res_slot_next = '0;
      case (item_func)
        FN_ALLOC: begin
          if (too_many) begin
            res_status_next = ST_TOO_MANY;
          end else if (item_count == '0) begin
            res_status_next = ST_OK;
          end else if (short_slots) begin
            res_status_next = ST_NO_SPACE;
          end else begin
            ptr_next       = '0;
            remaining_next = item_count;
          end
        end
        FN_FREE: begin
          if (!item_in_range) begin
            res_status_next = ST_RANGE;
          end else if (!used_map[item_idx[SLOT_W-1:0]]) begin
            res_status_next = ST_FREE;
          end else begin
            used_map_next[item_idx[SLOT_W-1:0]] = 1'b0;
            res_status_next = ST_OK;
            res_slot_next   = GSLOT_W'(item_idx);
          end
        end
        FN_CHAIN: begin
          cur_next       = item_idx;
          step_next      = '0;
          any_freed_next = 1'b0;
        end
        default: begin
          if (!item_in_range) begin
            res_status_next = ST_RANGE;
          end else begin
            link_flag_next[item_idx[SLOT_W-1:0]] = item_has_next;
            link_we         = 1'b1;
            res_status_next = ST_OK;
          end
        end
      endcase
    end

    // allocate scan: one slot a cycle, holding at a free slot until the output can take the grant
    if (cmd.alloc_step) begin
      if (!used_map[ptr]) begin
        if (out_free) begin
          used_map_next[ptr] = 1'b1;
          remaining_next     = remaining - CNT_W'(1);
          ptr_next           = ptr + SLOT_W'(1);
          out_load           = 1'b1;
          out_load_status    = ST_OK;
          out_load_slot      = GSLOT_W'(ptr);
          out_load_last      = (remaining == CNT_W'(1));
        end
      end else begin
        ptr_next = ptr + SLOT_W'(1);
      end
    end

    // chain walk: one slot a cycle
    if (cmd.chain_step) begin
      if (!cur_in_range) begin
        res_status_next = ST_RANGE;
      end else begin
        if (cur_used) begin
          used_map_next[cur[SLOT_W-1:0]] = 1'b0;
          res_slot_next  = GSLOT_W'(cur);
          any_freed_next = 1'b1;
        end
        if (chain_end) begin
          res_status_next = (any_freed || cur_used) ? ST_OK : ST_FREE;
        end else begin
          cur_next  = IDX_W'(link_target[cur[SLOT_W-1:0]]);
          step_next = step + STEP_W'(1);
        end
      end
    end

    // single result of the item
    if (cmd.emit && out_free) begin
      out_load = 1'b1;
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map  <= '0;
      link_flag <= '0;
      out_valid <= 1'b0;
    end else begin
      used_map  <= used_map_next;
      link_flag <= link_flag_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func     <= func;
      item_count    <= count;
      item_idx      <= slot_index;
      item_has_next <= has_next;
      item_next     <= next_slot;
    end
    if (link_we) begin
      link_target[item_idx[SLOT_W-1:0]] <= SLOT_W'(item_next);
    end
    ptr        <= ptr_next;
    remaining  <= remaining_next;
    cur        <= cur_next;
    step       <= step_next;
    any_freed  <= any_freed_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    if (out_load) begin
      status       <= out_load_status;
      granted_slot <= out_load_slot;
      last         <= out_load_last;
    end
  end

endmodule

`default_nettype wire

/* sim/ring_descriptor_allocator_tb.sv */
// ring_descriptor_allocator_tb: self-checking bench for the ring descriptor slot allocator
`timescale 1ns / 1ps

module ring_descriptor_allocator_tb;
  import rda_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 145;
  localparam int DRAIN_CYCLES  = 24;
  localparam int HANG_LIMIT    = 2000;
  localparam int IDLE_PERCENT  = 8;

  // one stimulus row, with an optional typed-in expectation
  typedef struct {
    logic [FUNC_W-1:0]   op;
    logic [CNT_W-1:0]    want_n;
    logic [IDX_W-1:0]    idx;
    logic                link_en;
    logic [NEXT_W-1:0]   link_to;
    bit                  typed;
    logic [STATUS_W-1:0] typed_status;
    logic [GSLOT_W-1:0]  typed_slot;
  } stim_row_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [GSLOT_W-1:0]  slot;
    logic                last;
  } grant_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [FUNC_W-1:0]   func;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    slot_index;
  logic                has_next;
  logic [NEXT_W-1:0]   next_slot;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [GSLOT_W-1:0]  granted_slot;
  logic                last;

  // typed expectation travelling with the item on the input port
  bit                  cur_typed;
  logic [STATUS_W-1:0] cur_typed_status;
  logic [GSLOT_W-1:0]  cur_typed_slot;

  bit                  calm;
  int                  errors;
  int                  hang_cycles;

  stim_row_t           directed_rows[$];
  grant_t              pending_grants[$];
  grant_t              fresh_grants[$];

  // predicted allocator state
  bit                  slot_busy[RING_DEPTH];
  bit                  chain_flag[RING_DEPTH];
  logic [SLOT_W-1:0]   chain_target[RING_DEPTH];

  ring_descriptor_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .count        (count),
    .slot_index   (slot_index),
    .has_next     (has_next),
    .next_slot    (next_slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .last         (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predict the results of one accepted item into fresh_grants
  task automatic predict_slots(input logic [FUNC_W-1:0] op, input logic [CNT_W-1:0] want_n,
                               input logic [IDX_W-1:0] idx, input logic link_en,
                               input logic [NEXT_W-1:0] link_to);
    int                 taken[$];
    int                 k;
    int                 s;
    int                 pick;
    bit                 ran_out;
    bit                 walk_done;
    bit                 hit_range;
    bit                 freed_any;
    logic [IDX_W-1:0]   at;
    logic [GSLOT_W-1:0] freed_last;
    fresh_grants.delete();
    case (op)
      FN_ALLOC: begin
        if (want_n >= RING_DEPTH || want_n > MAX_RESULTS) begin
          fresh_grants.push_back('{ST_TOO_MANY, '0, 1'b1});
        end else if (want_n == 0) begin
          fresh_grants.push_back('{ST_OK, '0, 1'b1});
        end else begin
          ran_out = 1'b0;
          for (k = 0; k < want_n && !ran_out; k++) begin
            pick = -1;
            for (s = 0; s < RING_DEPTH; s++) begin
              if (!slot_busy[s] && pick < 0) pick = s;
            end
            if (pick < 0) begin
              ran_out = 1'b1;
            end else begin
              slot_busy[pick] = 1'b1;
              taken.push_back(pick);
            end
          end
          if (ran_out) begin
            // roll back what this item took
            foreach (taken[t]) slot_busy[taken[t]] = 1'b0;
            fresh_grants.push_back('{ST_NO_SPACE, '0, 1'b1});
          end else begin
            for (k = 0; k < want_n; k++) begin
              fresh_grants.push_back('{ST_OK, taken[k][GSLOT_W-1:0], k == want_n - 1});
            end
          end
        end
      end
      FN_FREE: begin
        if (idx >= RING_DEPTH) begin
          fresh_grants.push_back('{ST_RANGE, '0, 1'b1});
        end else if (!slot_busy[idx]) begin
          fresh_grants.push_back('{ST_FREE, '0, 1'b1});
        end else begin
          slot_busy[idx] = 1'b0;
          fresh_grants.push_back('{ST_OK, idx[GSLOT_W-1:0], 1'b1});
        end
      end
      FN_CHAIN: begin
        // walk the links, at most one pass round the ring
        at = idx;
        freed_last = '0;
        freed_any = 1'b0;
        walk_done = 1'b0;
        hit_range = 1'b0;
        for (k = 0; k < RING_DEPTH && !walk_done; k++) begin
          if (at >= RING_DEPTH) begin
            hit_range = 1'b1;
            walk_done = 1'b1;
          end else begin
            if (slot_busy[at]) begin
              slot_busy[at] = 1'b0;
              freed_last = at[GSLOT_W-1:0];
              freed_any = 1'b1;
            end
            if (!chain_flag[at]) walk_done = 1'b1;
            else at = {1'b0, chain_target[at]};
          end
        end
        if (hit_range) fresh_grants.push_back('{ST_RANGE, freed_last, 1'b1});
        else fresh_grants.push_back('{freed_any ? ST_OK : ST_FREE, freed_last, 1'b1});
      end
      default: begin
        if (idx >= RING_DEPTH) begin
          fresh_grants.push_back('{ST_RANGE, '0, 1'b1});
        end else begin
          chain_flag[idx] = link_en;
          chain_target[idx] = link_to;
          fresh_grants.push_back('{ST_OK, '0, 1'b1});
        end
      end
    endcase
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] op, input int want_n, input int idx,
                         input bit link_en, input int link_to, input bit typed,
                         input logic [STATUS_W-1:0] st, input int sl);
    stim_row_t r;
    r.op = op;
    r.want_n = want_n[CNT_W-1:0];
    r.idx = idx[IDX_W-1:0];
    r.link_en = link_en;
    r.link_to = link_to[NEXT_W-1:0];
    r.typed = typed;
    r.typed_status = st;
    r.typed_slot = sl[GSLOT_W-1:0];
    directed_rows.push_back(r);
  endtask

  // present one item and hold it until accepted
  task automatic drive_item(input stim_row_t r);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= r.op;
    count <= r.want_n;
    slot_index <= r.idx;
    has_next <= r.link_en;
    next_slot <= r.link_to;
    cur_typed <= r.typed;
    cur_typed_status <= r.typed_status;
    cur_typed_slot <= r.typed_slot;
    do @(posedge clk); while (in_stall);
  endtask

  // accepted input items feed the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_slots(func, count, slot_index, has_next, next_slot);
      if (cur_typed) begin
        pending_grants.push_back('{cur_typed_status, cur_typed_slot, 1'b1});
      end else begin
        foreach (fresh_grants[g]) pending_grants.push_back(fresh_grants[g]);
      end
    end
  end

  // accepted results against the oldest expectation
  always @(posedge clk) begin : check_results
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d last %0d",
                 $time, status, granted_slot, last);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (granted_slot !== want.slot) begin
          $display("%0t: granted_slot mismatch, expected %0d actual %0d",
                   $time, want.slot, granted_slot);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last mismatch, expected %0d actual %0d", $time, want.last, last);
          errors++;
        end
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
  end

  // hang watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) hang_cycles <= 0;
    else hang_cycles <= hang_cycles + 1;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("ring_descriptor_allocator verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int        n;
    int        pick;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_ALLOC;
    count = '0;
    slot_index = '0;
    has_next = 1'b0;
    next_slot = '0;
    out_stall = 1'b0;
    cur_typed = 1'b0;
    cur_typed_status = ST_OK;
    cur_typed_slot = '0;
    calm = 1'b0;
    errors = 0;
    hang_cycles = 0;
    for (n = 0; n < RING_DEPTH; n++) begin
      slot_busy[n] = 1'b0;
      chain_flag[n] = 1'b0;
      chain_target[n] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty ring, range and size extremes
    add_row(FN_FREE,   0,  3, 1'b1, 7, 1'b1, ST_FREE,     0);
    add_row(FN_CHAIN,  0,  0, 1'b0, 0, 1'b1, ST_FREE,     0);
    add_row(FN_ALLOC,  0,  0, 1'b0, 0, 1'b1, ST_OK,       0);
    add_row(FN_ALLOC,  8,  0, 1'b0, 0, 1'b1, ST_TOO_MANY, 0);
    add_row(FN_ALLOC, 15, 15, 1'b1, 7, 1'b1, ST_TOO_MANY, 0);
    add_row(FN_FREE,   0, 15, 1'b0, 0, 1'b1, ST_RANGE,    0);
    add_row(FN_FREE,   0,  8, 1'b0, 0, 1'b1, ST_RANGE,    0);
    add_row(FN_LINK,   0, 12, 1'b1, 5, 1'b1, ST_RANGE,    0);
    add_row(FN_CHAIN,  0,  9, 1'b0, 0, 1'b1, ST_RANGE,    0);
    add_row(FN_ALLOC,  1,  0, 1'b0, 0, 1'b1, ST_OK,       0);
    // fill the ring, then one too many
    add_row(FN_ALLOC,  7,  0, 1'b0, 0, 1'b0, ST_OK,       0);
    add_row(FN_ALLOC,  1,  0, 1'b0, 0, 1'b1, ST_NO_SPACE, 0);
    // chain 0 -> 7 -> 3 and walk it
    add_row(FN_LINK,   0,  0, 1'b1, 7, 1'b1, ST_OK,       0);
    add_row(FN_LINK,   0,  7, 1'b1, 3, 1'b0, ST_OK,       0);
    add_row(FN_LINK,   0,  3, 1'b0, 5, 1'b0, ST_OK,       0);
    add_row(FN_CHAIN,  0,  0, 1'b0, 0, 1'b0, ST_OK,       0);
    add_row(FN_FREE,   0,  0, 1'b0, 0, 1'b0, ST_OK,       0);
    add_row(FN_FREE,   0,  5, 1'b0, 0, 1'b0, ST_OK,       0);
    add_row(FN_ALLOC,  4,  0, 1'b0, 0, 1'b0, ST_OK,       0);
    // self loop: walk bounded to the ring depth
    add_row(FN_LINK,   0,  1, 1'b1, 1, 1'b0, ST_OK,       0);
    add_row(FN_CHAIN,  0,  1, 1'b0, 0, 1'b0, ST_OK,       0);
    // asks for more slots than are free: rejected, nothing taken
    add_row(FN_ALLOC,  7,  0, 1'b0, 0, 1'b0, ST_OK,       0);
    add_row(FN_LINK,   0,  6, 1'b0, 0, 1'b0, ST_OK,       0);
    add_row(FN_FREE,   0,  4, 1'b0, 0, 1'b0, ST_OK,       0);
    add_row(FN_CHAIN,  0,  6, 1'b0, 0, 1'b0, ST_OK,       0);

    foreach (directed_rows[d]) drive_item(directed_rows[d]);

    // random items, mostly small allocations, links and frees
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 60 && n < 110);
      r.typed = 1'b0;
      r.typed_status = ST_OK;
      r.typed_slot = '0;
      r.link_en = ($urandom_range(99) < 70);
      r.link_to = NEXT_W'($urandom_range(RING_DEPTH - 1));
      r.want_n = CNT_W'($urandom_range(15));
      r.idx = ($urandom_range(99) < 10) ? IDX_W'($urandom_range(15, RING_DEPTH)) :
                                          IDX_W'($urandom_range(RING_DEPTH - 1));
      pick = $urandom_range(99);
      if (pick < 35) begin
        r.op = FN_ALLOC;
        pick = $urandom_range(99);
        if (pick < 70) r.want_n = CNT_W'($urandom_range(3, 1));
        else if (pick < 80) r.want_n = '0;
        else if (pick < 90) r.want_n = CNT_W'($urandom_range(MAX_RESULTS, 4));
      end else if (pick < 55) begin
        r.op = FN_FREE;
      end else if (pick < 70) begin
        r.op = FN_CHAIN;
      end else begin
        r.op = FN_LINK;
      end
      drive_item(r);
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;

    // drain the expected results, then let the block settle
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_grants.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, pending_grants.size());
      errors++;
    end

    if (errors == 0) begin
      $display("ring_descriptor_allocator verification clean");
    end else begin
      $display("ring_descriptor_allocator verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/rda_pkg.sv
src/rda_ctrl.sv
src/rda_dp.sv
src/ring_descriptor_allocator.sv
sim/ring_descriptor_allocator_tb.sv
